FILE: rtl/tlsf_heap_allocator_macros.svh
// ----------------------------------------------------------------------------
// TLSF allocator assertion macros
// Property wrappers used by the allocator; empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef TLSF_HEAP_ALLOCATOR_MACROS_SVH
`define TLSF_HEAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define TLSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, checked out of reset
`define TLSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLSF_ASSERT_NOW(lbl, ante, cons, msg)
`define TLSF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/tlsf_pkg.sv
// ----------------------------------------------------------------------------
// TLSF allocator package
// Constants, descriptor types and class mapping for the allocator.
// ----------------------------------------------------------------------------
package tlsf_pkg;

  localparam int HEAP_BYTES = 65536;
  localparam int SLB        = 4;
  localparam int HDR        = 48;
  localparam int FL         = 17;
  localparam int SLOTS      = HEAP_BYTES / 16;
  localparam int SL_COUNT   = 1 << SLB;
  localparam int HEAD_DEPTH = FL * SL_COUNT;

  localparam logic [12:0] NIL = 13'(SLOTS);

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_OOM      = 2'd2;
  localparam logic [1:0] ST_BAD_FREE = 2'd3;

  // field write masks for the link memory
  localparam logic [3:0] LM_LEFT  = 4'b1000;
  localparam logic [3:0] LM_RIGHT = 4'b0100;
  localparam logic [3:0] LM_NEXT  = 4'b0010;
  localparam logic [3:0] LM_PREV  = 4'b0001;

  typedef struct packed {
    logic [12:0] left;
    logic [12:0] right;
    logic [12:0] next;
    logic [12:0] prev;
  } links_t;

  typedef struct packed {
    logic [4:0] f;
    logic [3:0] s;
  } cls_t;

  function automatic logic [4:0] top_bit(input logic [17:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 0; i < 18; i++) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  function automatic logic [4:0] low_bit17(input logic [16:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 16; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  function automatic logic [3:0] low_bit16(input logic [15:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  function automatic cls_t class_of(input logic [17:0] size);
    logic [4:0]  hi;
    logic [4:0]  sh;
    logic [17:0] t;
    cls_t        c;
    hi  = top_bit(size);
    sh  = (hi >= 5'(SLB)) ? hi - 5'(SLB) : 5'd0;
    t   = (size ^ (18'd1 << hi)) >> sh;
    c.f = hi;
    c.s = t[3:0];
    if (hi >= 5'(FL)) begin
      c.f = 5'(FL - 1);
      c.s = '1;
    end
    return c;
  endfunction

  function automatic logic [8:0] head_addr(input logic [4:0] f, input logic [3:0] s);
    return 9'(f) * 9'(SL_COUNT) + 9'(s);
  endfunction

endpackage

FILE: rtl/tlsf_heap_allocator.sv
// ----------------------------------------------------------------------------
// TLSF heap allocator
// Two-level segregated-fit allocator with descriptors held in on-chip RAM.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  request  | start / busy         | in_operation, in_request_bytes,
//           |                      | in_user_address
//  result   | out_strobe (1 cycle) | out_granted_address, out_status
//  config   | cfg_write_en         | cfg_write_data (heap limit)
//
//  A request is taken when start is high and busy is low; one result follows.
//  A request runs from acceptance to the strobe as a sequence of steps: each step does
//  at most one read and one write on each descriptor RAM (the read is registered),
//  so a free with merges on both sides is the longest request.
//  Reset is synchronous; it empties the bitmaps and the heap. The descriptor
//  RAMs need no clearing, and list heads are only read behind a set bitmap bit.
//  The result port cannot be stalled: out_strobe is high for one cycle only.
//
module tlsf_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [16:0] in_request_bytes,
  input  logic [15:0] in_user_address,
  output logic        out_strobe,
  output logic [15:0] out_granted_address,
  output logic [1:0]  out_status,
  input  logic        cfg_write_en,
  input  logic [16:0] cfg_write_data
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_AROUND = 5'd1;
  localparam logic [4:0] S_ACLASS = 5'd2;
  localparam logic [4:0] S_AFIND  = 5'd3;
  localparam logic [4:0] S_AFIND2 = 5'd4;
  localparam logic [4:0] S_AHEAD  = 5'd5;
  localparam logic [4:0] S_ATAKE  = 5'd6;
  localparam logic [4:0] S_ASPLIT = 5'd7;
  localparam logic [4:0] S_ASPL2  = 5'd8;
  localparam logic [4:0] S_ASPL3  = 5'd9;
  localparam logic [4:0] S_FRD    = 5'd10;
  localparam logic [4:0] S_FCHK   = 5'd11;
  localparam logic [4:0] S_FRRD   = 5'd12;
  localparam logic [4:0] S_FRMRG  = 5'd13;
  localparam logic [4:0] S_FRMRG2 = 5'd14;
  localparam logic [4:0] S_FLEFT  = 5'd15;
  localparam logic [4:0] S_FLRD   = 5'd16;
  localparam logic [4:0] S_FLMRG  = 5'd17;
  localparam logic [4:0] S_FLMRG2 = 5'd18;
  localparam logic [4:0] S_U1     = 5'd19;
  localparam logic [4:0] S_U2     = 5'd20;
  localparam logic [4:0] S_PCLASS = 5'd21;
  localparam logic [4:0] S_PHEAD  = 5'd22;
  localparam logic [4:0] S_PLINK  = 5'd23;
  localparam logic [4:0] S_FIN    = 5'd24;

  // control state
  logic [4:0]  st_r, st_nxt;
  logic [4:0]  ret_r, ret_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [16:0] lim_r, lim_nxt;
  logic [16:0] top_r, top_nxt;
  logic [16:0] flbm_r, flbm_nxt;
  logic [15:0] slbm_r [tlsf_pkg::FL];
  logic [15:0] slbm_nxt [tlsf_pkg::FL];

  // working registers
  logic [17:0] a_r, a_nxt;
  logic [4:0]  f_r, f_nxt;
  logic [3:0]  s_r, s_nxt;
  logic [15:0] msk_r, msk_nxt;
  logic [11:0] b_r, b_nxt;
  logic [16:0] sz_r, sz_nxt;
  logic [12:0] lft_r, lft_nxt;
  logic [12:0] rgt_r, rgt_nxt;
  logic [11:0] x_r, x_nxt;
  logic [16:0] xsz_r, xsz_nxt;
  logic [12:0] xr_r, xr_nxt;
  logic [12:0] up_r, up_nxt;
  logic [12:0] un_r, un_nxt;
  logic [4:0]  uf_r, uf_nxt;
  logic [3:0]  us_r, us_nxt;
  logic [11:0] pb_r, pb_nxt;
  logic [16:0] psz_r, psz_nxt;
  logic [12:0] ph_r, ph_nxt;
  logic [15:0] oaddr_r, oaddr_nxt;
  logic [1:0]  ostat_r, ostat_nxt;

  // descriptor memories
  logic [17:0]          info_mem [tlsf_pkg::SLOTS];
  tlsf_pkg::links_t     link_mem [tlsf_pkg::SLOTS];
  logic [12:0]          head_mem [tlsf_pkg::HEAD_DEPTH];

  logic [11:0]      info_ra, info_wa, link_ra, link_wa;
  logic             info_we, head_we;
  logic [17:0]      info_wd, info_q;
  logic [3:0]       link_wm;
  tlsf_pkg::links_t link_wd, link_q;
  logic [8:0]       head_ra, head_wa;
  logic [12:0]      head_wd, head_q;

  // single read port on the second-level bitmaps
  logic [4:0]  sl_idx;
  logic [15:0] sl_row;
  logic [16:0] sl_nz;

  assign sl_row = slbm_r[sl_idx];

  always_comb begin
    for (int i = 0; i < tlsf_pkg::FL; i++) begin
      sl_nz[i] = |slbm_r[i];
    end
  end

  assign busy                = (st_r != S_IDLE);
  assign out_strobe          = out_valid_r;
  assign out_granted_address = oaddr_r;
  assign out_status          = ostat_r;

  // main sequencer
  always_comb begin
    logic [15:0]   u_off;
    logic [17:0]   a0;
    logic [4:0]    f0;
    logic [4:0]    sh;
    logic [17:0]   rmask;
    logic [4:0]    hi;
    tlsf_pkg::cls_t c;
    logic [15:0]   m1;
    logic [16:0]   m2;
    logic [15:0]   m;
    logic [16:0]   lim;
    logic [17:0]   need;
    logic [13:0]   b2w;
    logic          split;
    logic [16:0]   rem;
    logic [16:0]   nsz;
    logic [12:0]   h;
    logic [15:0]   nsl;

    st_nxt        = st_r;
    ret_nxt       = ret_r;
    out_valid_nxt = 1'b0;
    lim_nxt       = cfg_write_en ? cfg_write_data : lim_r;
    top_nxt       = top_r;
    flbm_nxt      = flbm_r;
    slbm_nxt      = slbm_r;
    a_nxt         = a_r;
    f_nxt         = f_r;
    s_nxt         = s_r;
    msk_nxt       = msk_r;
    b_nxt         = b_r;
    sz_nxt        = sz_r;
    lft_nxt       = lft_r;
    rgt_nxt       = rgt_r;
    x_nxt         = x_r;
    xsz_nxt       = xsz_r;
    xr_nxt        = xr_r;
    up_nxt        = up_r;
    un_nxt        = un_r;
    uf_nxt        = uf_r;
    us_nxt        = us_r;
    pb_nxt        = pb_r;
    psz_nxt       = psz_r;
    ph_nxt        = ph_r;
    oaddr_nxt     = oaddr_r;
    ostat_nxt     = ostat_r;

    info_ra = '0;
    info_we = 1'b0;
    info_wa = '0;
    info_wd = '0;
    link_ra = '0;
    link_wm = '0;
    link_wa = '0;
    link_wd = '0;
    head_ra = '0;
    head_we = 1'b0;
    head_wa = '0;
    head_wd = '0;
    sl_idx  = f_r;

    u_off = in_user_address - 16'(tlsf_pkg::HDR);
    a0    = (a_r + 18'd15) & ~18'd15;
    f0    = tlsf_pkg::top_bit(a0);
    sh    = (f0 >= 5'(tlsf_pkg::SLB)) ? f0 - 5'(tlsf_pkg::SLB) : 5'd0;
    rmask = (18'd1 << sh) - 18'd1;
    hi    = tlsf_pkg::top_bit(a_r);
    c     = tlsf_pkg::class_of(a_r);
    m1    = '0;
    m2    = '0;
    m     = '0;
    lim   = (lim_r > 17'(tlsf_pkg::HEAP_BYTES)) ? 17'(tlsf_pkg::HEAP_BYTES) : lim_r;
    need  = {1'b0, top_r} + 18'(tlsf_pkg::HDR) + a_r;
    b2w   = {2'b00, b_r} + 14'((a_r + 18'(tlsf_pkg::HDR)) >> 4);
    split = ({1'b0, sz_r} >= a_r + 18'd16 + 18'(tlsf_pkg::HDR));
    rem   = sz_r - a_r[16:0] - 17'(tlsf_pkg::HDR);
    nsz   = sz_r + xsz_r + 17'(tlsf_pkg::HDR);
    h     = tlsf_pkg::NIL;
    nsl   = '0;

    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          oaddr_nxt = '0;
          ostat_nxt = tlsf_pkg::ST_OK;
          if (in_operation == tlsf_pkg::OP_FREE) begin
            if (in_user_address == 16'd0) begin
              st_nxt = S_FIN;
            end else if (in_user_address < 16'(tlsf_pkg::HDR) || u_off[3:0] != 4'd0 ||
                         {1'b0, u_off} >= top_r) begin
              ostat_nxt = tlsf_pkg::ST_BAD_FREE;
              st_nxt    = S_FIN;
            end else begin
              b_nxt  = u_off[15:4];
              st_nxt = S_FRD;
            end
          end else begin
            if (in_request_bytes == 17'd0) begin
              ostat_nxt = tlsf_pkg::ST_ZERO;
              st_nxt    = S_FIN;
            end else begin
              a_nxt  = {1'b0, in_request_bytes};
              st_nxt = S_AROUND;
            end
          end
        end
      end
      // round to 16 bytes, then to the second-level granule
      S_AROUND: begin
        a_nxt  = (a0 + rmask) & ~rmask;
        st_nxt = S_ACLASS;
      end
      S_ACLASS: begin
        if (hi >= 5'(tlsf_pkg::FL)) begin
          ostat_nxt = tlsf_pkg::ST_OOM;
          st_nxt    = S_FIN;
        end else begin
          f_nxt  = c.f;
          s_nxt  = c.s;
          st_nxt = S_AFIND;
        end
      end
      // pick the first level to search; the row itself is read next cycle
      S_AFIND: begin
        sl_idx = f_r;
        m1     = sl_row & (16'hFFFF << s_r);
        m2     = flbm_r & (17'h1FFFF << ({1'b0, f_r} + 6'd1));
        if (flbm_r[f_r] && m1 != 16'd0) begin
          msk_nxt = 16'hFFFF << s_r;
        end else if (m2 != 17'd0) begin
          f_nxt   = tlsf_pkg::low_bit17(m2);
          msk_nxt = 16'hFFFF;
        end else begin
          msk_nxt = '0;
        end
        st_nxt = S_AFIND2;
      end
      S_AFIND2: begin
        sl_idx = f_r;
        m      = sl_row & msk_r;
        if (m != 16'd0) begin
          s_nxt   = tlsf_pkg::low_bit16(m);
          head_ra = tlsf_pkg::head_addr(f_r, tlsf_pkg::low_bit16(m));
          st_nxt  = S_AHEAD;
        end else if (need > {1'b0, lim}) begin
          ostat_nxt = tlsf_pkg::ST_OOM;
          st_nxt    = S_FIN;
        end else begin
          // bump a fresh block at the heap top
          info_we   = 1'b1;
          info_wa   = top_r[15:4];
          info_wd   = {a_r[16:0], 1'b1};
          link_wm   = tlsf_pkg::LM_LEFT | tlsf_pkg::LM_RIGHT |
                      tlsf_pkg::LM_NEXT | tlsf_pkg::LM_PREV;
          link_wa   = top_r[15:4];
          link_wd   = '{left: tlsf_pkg::NIL, right: tlsf_pkg::NIL,
                        next: tlsf_pkg::NIL, prev: tlsf_pkg::NIL};
          top_nxt   = need[16:0];
          oaddr_nxt = top_r[15:0] + 16'(tlsf_pkg::HDR);
          st_nxt    = S_FIN;
        end
      end
      S_AHEAD: begin
        b_nxt   = head_q[11:0];
        info_ra = head_q[11:0];
        link_ra = head_q[11:0];
        st_nxt  = S_ATAKE;
      end
      S_ATAKE: begin
        sz_nxt    = info_q[17:1];
        rgt_nxt   = link_q.right;
        up_nxt    = link_q.prev;
        un_nxt    = link_q.next;
        uf_nxt    = f_r;
        us_nxt    = s_r;
        oaddr_nxt = {b_r, 4'h0} + 16'(tlsf_pkg::HDR);
        ret_nxt   = S_ASPLIT;
        st_nxt    = S_U1;
      end
      S_ASPLIT: begin
        info_we = 1'b1;
        if (split && b2w < 14'(tlsf_pkg::SLOTS)) begin
          info_wa = b2w[11:0];
          info_wd = {rem, 1'b0};
          link_wm = tlsf_pkg::LM_LEFT | tlsf_pkg::LM_RIGHT;
          link_wa = b2w[11:0];
          link_wd.left  = {1'b0, b_r};
          link_wd.right = rgt_r;
          x_nxt   = b2w[11:0];
          psz_nxt = rem;
          st_nxt  = S_ASPL2;
        end else begin
          info_wa = b_r;
          info_wd = {sz_r, 1'b1};
          st_nxt  = S_FIN;
        end
      end
      S_ASPL2: begin
        if (rgt_r < tlsf_pkg::NIL) begin
          link_wm      = tlsf_pkg::LM_LEFT;
          link_wa      = rgt_r[11:0];
          link_wd.left = {1'b0, x_r};
        end
        st_nxt = S_ASPL3;
      end
      S_ASPL3: begin
        link_wm       = tlsf_pkg::LM_RIGHT;
        link_wa       = b_r;
        link_wd.right = {1'b0, x_r};
        info_we       = 1'b1;
        info_wa       = b_r;
        info_wd       = {a_r[16:0], 1'b1};
        pb_nxt        = x_r;
        st_nxt        = S_PCLASS;
      end
      S_FRD: begin
        info_ra = b_r;
        link_ra = b_r;
        st_nxt  = S_FCHK;
      end
      S_FCHK: begin
        if (!info_q[0]) begin
          ostat_nxt = tlsf_pkg::ST_BAD_FREE;
          st_nxt    = S_FIN;
        end else begin
          info_we = 1'b1;
          info_wa = b_r;
          info_wd = {info_q[17:1], 1'b0};
          sz_nxt  = info_q[17:1];
          lft_nxt = link_q.left;
          rgt_nxt = link_q.right;
          if (link_q.right < tlsf_pkg::NIL) begin
            info_ra = link_q.right[11:0];
            link_ra = link_q.right[11:0];
            st_nxt  = S_FRRD;
          end else begin
            st_nxt = S_FLEFT;
          end
        end
      end
      S_FRRD: begin
        if (!info_q[0]) begin
          c       = tlsf_pkg::class_of({1'b0, info_q[17:1]});
          xsz_nxt = info_q[17:1];
          xr_nxt  = link_q.right;
          up_nxt  = link_q.prev;
          un_nxt  = link_q.next;
          uf_nxt  = c.f;
          us_nxt  = c.s;
          ret_nxt = S_FRMRG;
          st_nxt  = S_U1;
        end else begin
          st_nxt = S_FLEFT;
        end
      end
      // absorb the right neighbour
      S_FRMRG: begin
        info_we       = 1'b1;
        info_wa       = b_r;
        info_wd       = {nsz, 1'b0};
        link_wm       = tlsf_pkg::LM_RIGHT;
        link_wa       = b_r;
        link_wd.right = xr_r;
        sz_nxt        = nsz;
        rgt_nxt       = xr_r;
        st_nxt        = S_FRMRG2;
      end
      S_FRMRG2: begin
        if (rgt_r < tlsf_pkg::NIL) begin
          link_wm      = tlsf_pkg::LM_LEFT;
          link_wa      = rgt_r[11:0];
          link_wd.left = {1'b0, b_r};
        end
        st_nxt = S_FLEFT;
      end
      S_FLEFT: begin
        if (lft_r < tlsf_pkg::NIL) begin
          info_ra = lft_r[11:0];
          link_ra = lft_r[11:0];
          st_nxt  = S_FLRD;
        end else begin
          pb_nxt  = b_r;
          psz_nxt = sz_r;
          st_nxt  = S_PCLASS;
        end
      end
      S_FLRD: begin
        if (!info_q[0]) begin
          c       = tlsf_pkg::class_of({1'b0, info_q[17:1]});
          xsz_nxt = info_q[17:1];
          up_nxt  = link_q.prev;
          un_nxt  = link_q.next;
          uf_nxt  = c.f;
          us_nxt  = c.s;
          ret_nxt = S_FLMRG;
          st_nxt  = S_U1;
        end else begin
          pb_nxt  = b_r;
          psz_nxt = sz_r;
          st_nxt  = S_PCLASS;
        end
      end
      // fold the block into its left neighbour
      S_FLMRG: begin
        info_we       = 1'b1;
        info_wa       = lft_r[11:0];
        info_wd       = {nsz, 1'b0};
        link_wm       = tlsf_pkg::LM_RIGHT;
        link_wa       = lft_r[11:0];
        link_wd.right = rgt_r;
        b_nxt         = lft_r[11:0];
        sz_nxt        = nsz;
        st_nxt        = S_FLMRG2;
      end
      S_FLMRG2: begin
        if (rgt_r < tlsf_pkg::NIL) begin
          link_wm      = tlsf_pkg::LM_LEFT;
          link_wa      = rgt_r[11:0];
          link_wd.left = {1'b0, b_r};
        end
        pb_nxt  = b_r;
        psz_nxt = sz_r;
        st_nxt  = S_PCLASS;
      end
      // unlink: predecessor (or list head), then successor
      S_U1: begin
        sl_idx = uf_r;
        if (up_r < tlsf_pkg::NIL) begin
          link_wm      = tlsf_pkg::LM_NEXT;
          link_wa      = up_r[11:0];
          link_wd.next = un_r;
        end else begin
          head_we = 1'b1;
          head_wa = tlsf_pkg::head_addr(uf_r, us_r);
          head_wd = un_r;
          if (un_r >= tlsf_pkg::NIL) begin
            nsl              = sl_row & ~(16'd1 << us_r);
            slbm_nxt[uf_r]   = nsl;
            if (nsl == 16'd0) flbm_nxt[uf_r] = 1'b0;
          end
        end
        st_nxt = S_U2;
      end
      S_U2: begin
        if (un_r < tlsf_pkg::NIL) begin
          link_wm      = tlsf_pkg::LM_PREV;
          link_wa      = un_r[11:0];
          link_wd.prev = up_r;
        end
        st_nxt = ret_r;
      end
      // push on the head of the class list
      S_PCLASS: begin
        c       = tlsf_pkg::class_of({1'b0, psz_r});
        f_nxt   = c.f;
        s_nxt   = c.s;
        head_ra = tlsf_pkg::head_addr(c.f, c.s);
        st_nxt  = S_PHEAD;
      end
      S_PHEAD: begin
        sl_idx = f_r;
        h      = sl_row[s_r] ? head_q : tlsf_pkg::NIL;
        ph_nxt = h;
        link_wm      = tlsf_pkg::LM_NEXT | tlsf_pkg::LM_PREV;
        link_wa      = pb_r;
        link_wd.next = h;
        link_wd.prev = tlsf_pkg::NIL;
        head_we      = 1'b1;
        head_wa      = tlsf_pkg::head_addr(f_r, s_r);
        head_wd      = {1'b0, pb_r};
        slbm_nxt[f_r] = sl_row | (16'd1 << s_r);
        flbm_nxt[f_r] = 1'b1;
        st_nxt        = S_PLINK;
      end
      S_PLINK: begin
        if (ph_r < tlsf_pkg::NIL) begin
          link_wm      = tlsf_pkg::LM_PREV;
          link_wa      = ph_r[11:0];
          link_wd.prev = {1'b0, pb_r};
        end
        st_nxt = S_FIN;
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        st_nxt        = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      lim_r       <= 17'(tlsf_pkg::HEAP_BYTES);
      top_r       <= '0;
      flbm_r      <= '0;
      for (int i = 0; i < tlsf_pkg::FL; i++) begin
        slbm_r[i] <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      lim_r       <= lim_nxt;
      top_r       <= top_nxt;
      flbm_r      <= flbm_nxt;
      slbm_r      <= slbm_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    f_r     <= f_nxt;
    s_r     <= s_nxt;
    msk_r   <= msk_nxt;
    b_r     <= b_nxt;
    sz_r    <= sz_nxt;
    lft_r   <= lft_nxt;
    rgt_r   <= rgt_nxt;
    x_r     <= x_nxt;
    xsz_r   <= xsz_nxt;
    xr_r    <= xr_nxt;
    up_r    <= up_nxt;
    un_r    <= un_nxt;
    uf_r    <= uf_nxt;
    us_r    <= us_nxt;
    pb_r    <= pb_nxt;
    psz_r   <= psz_nxt;
    ph_r    <= ph_nxt;
    oaddr_r <= oaddr_nxt;
    ostat_r <= ostat_nxt;
  end

  // descriptor RAMs: one write and one registered read a cycle each
  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    info_q <= info_mem[info_ra];
  end

  always_ff @(posedge clk) begin
    if (link_wm[3]) link_mem[link_wa].left  <= link_wd.left;
    if (link_wm[2]) link_mem[link_wa].right <= link_wd.right;
    if (link_wm[1]) link_mem[link_wa].next  <= link_wd.next;
    if (link_wm[0]) link_mem[link_wa].prev  <= link_wd.prev;
    link_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_q <= head_mem[head_ra];
  end

  `include "tlsf_heap_allocator_macros.svh"

  `TLSF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `TLSF_ASSERT_NOW(a_strobe_after_work, out_strobe, $past(busy), "result without a request")
  `TLSF_ASSERT_NOW(a_bitmap_match, 1'b1, flbm_r == sl_nz, "first-level bitmap out of step")
  `TLSF_ASSERT_NOW(a_top_bound, 1'b1, top_r <= 17'(tlsf_pkg::HEAP_BYTES), "heap top overrun")

endmodule
